/* rtl/bbs_pkg.sv */
// Shared types for the bidirectional bubble sorter: beat payloads and sequencer states.
package bbs_pkg;

   typedef struct packed {
      logic signed [31:0] value;
      logic               is_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_set;
      logic               overflow;
   } rsp_payload_type;

   typedef enum logic [8:0] {
      S_LOAD   = 9'b000000001,
      S_F_LOAD = 9'b000000010,
      S_F_CMP  = 9'b000000100,
      S_F_END  = 9'b000001000,
      S_B_LOAD = 9'b000010000,
      S_B_CMP  = 9'b000100000,
      S_B_END  = 9'b001000000,
      S_E_RD   = 9'b010000000,
      S_E_WR   = 9'b100000000
   } state_type;

endpackage

/* rtl/bbs_stream_if.sv */
// Valid/ready stream channel carrying one payload beat per handshake.
interface bbs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/bidirectional_bubble_sorter_unit.sv */
// Top level: element store, shaker-sort sequencer with one shared compare unit, output register.
// Load: one beat per cycle while collecting; the closing beat starts the sort, or the emit for a set of fewer than two.
// Sort: each pass runs a load step, then one compare-and-swap per cycle through the
//   single-read, single-write store, then an end step that writes the carried value back.
// Emit: a setup state reads slot 0, then one result per cycle while the sink keeps ready high.
// Synchronous active-high reset clears count, bounds, flags and state; store is not cleared.
module bidirectional_bubble_sorter_unit #(
   parameter int ENTRIES = 32
) (
   input logic clock,
   input logic reset,
   bbs_stream_if.sink   req_ch,
   bbs_stream_if.source rsp_ch
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

   // element store
   logic signed [31:0] store_mem [ENTRIES];
   logic signed [31:0] rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] wr_data;
   logic [IDX_W-1:0]   rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   bbs_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       lo_ff, lo_in;
   logic [IDX_W-1:0]       hi_ff, hi_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [IDX_W-1:0]       mark_ff, mark_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic signed [31:0]     cur_ff, cur_in;
   logic                   swapped_ff, swapped_in;
   logic                   dropped_ff, dropped_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   bbs_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic             req_fire;
   logic             gt;
   logic [CNT_W-1:0] n_new;
   logic             emit_last;

   assign req_ch.ready   = (state_ff == bbs_pkg::S_LOAD);
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   assign n_new     = (count_ff < ENTRIES_C) ? count_ff + CNT_W'(1) : count_ff;
   assign emit_last = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;

   // shared compare: forward carries the larger value up, backward the smaller one down
   assign gt = (state_ff == bbs_pkg::S_B_CMP) ? (rd_data_ff > cur_ff) : (cur_ff > rd_data_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      mark_in      = mark_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      swapped_in   = swapped_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = j_ff;
      wr_data      = cur_ff;
      rd_addr      = k_ff;

      unique case (state_ff)
         bbs_pkg::S_LOAD: begin
            if (req_fire) begin
               if (count_ff < ENTRIES_C) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  wr_data  = req_ch.payload.value;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_ch.payload.is_last) begin
                  if (n_new >= CNT_W'(2)) begin
                     lo_in    = '0;
                     hi_in    = IDX_W'(n_new - CNT_W'(1));
                     rd_addr  = '0;
                     state_in = bbs_pkg::S_F_LOAD;
                  end else begin
                     state_in = bbs_pkg::S_E_RD;
                  end
               end
            end
         end
         bbs_pkg::S_F_LOAD: begin
            cur_in     = rd_data_ff;
            j_in       = lo_ff;
            mark_in    = lo_ff;
            swapped_in = 1'b0;
            rd_addr    = lo_ff + IDX_W'(1);
            state_in   = bbs_pkg::S_F_CMP;
         end
         bbs_pkg::S_F_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = gt ? rd_data_ff : cur_ff;
            cur_in  = gt ? cur_ff : rd_data_ff;
            if (gt) begin
               mark_in    = j_ff;
               swapped_in = 1'b1;
            end
            if ((j_ff + IDX_W'(1)) == hi_ff) begin
               state_in = bbs_pkg::S_F_END;
            end else begin
               j_in    = j_ff + IDX_W'(1);
               rd_addr = j_ff + IDX_W'(2);
            end
         end
         bbs_pkg::S_F_END: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = cur_ff;
            if (!swapped_ff) begin
               state_in = bbs_pkg::S_E_RD;
            end else begin
               hi_in = mark_ff;
               if (lo_ff < mark_ff) begin
                  rd_addr  = mark_ff;
                  state_in = bbs_pkg::S_B_LOAD;
               end else begin
                  state_in = bbs_pkg::S_E_RD;
               end
            end
         end
         bbs_pkg::S_B_LOAD: begin
            cur_in     = rd_data_ff;
            j_in       = hi_ff;
            mark_in    = hi_ff;
            swapped_in = 1'b0;
            rd_addr    = hi_ff - IDX_W'(1);
            state_in   = bbs_pkg::S_B_CMP;
         end
         bbs_pkg::S_B_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = gt ? rd_data_ff : cur_ff;
            cur_in  = gt ? cur_ff : rd_data_ff;
            if (gt) begin
               mark_in    = j_ff;
               swapped_in = 1'b1;
            end
            if (j_ff == (lo_ff + IDX_W'(1))) begin
               state_in = bbs_pkg::S_B_END;
            end else begin
               j_in    = j_ff - IDX_W'(1);
               rd_addr = j_ff - IDX_W'(2);
            end
         end
         bbs_pkg::S_B_END: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = cur_ff;
            if (!swapped_ff) begin
               state_in = bbs_pkg::S_E_RD;
            end else begin
               lo_in = mark_ff;
               if (mark_ff < hi_ff) begin
                  rd_addr  = mark_ff;
                  state_in = bbs_pkg::S_F_LOAD;
               end else begin
                  state_in = bbs_pkg::S_E_RD;
               end
            end
         end
         bbs_pkg::S_E_RD: begin
            // k is zero here; read slot 0
            rd_addr  = k_ff;
            state_in = bbs_pkg::S_E_WR;
         end
         bbs_pkg::S_E_WR: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = rd_data_ff;
               rsp_data_in.end_of_set   = emit_last;
               rsp_data_in.overflow     = dropped_ff;
               if (emit_last) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  lo_in      = '0;
                  hi_in      = '0;
                  k_in       = '0;
                  state_in   = bbs_pkg::S_LOAD;
               end else begin
                  k_in    = k_ff + IDX_W'(1);
                  rd_addr = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = bbs_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbs_pkg::S_LOAD;
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         k_ff         <= '0;
         dropped_ff   <= 1'b0;
         swapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         k_ff         <= k_in;
         dropped_ff   <= dropped_in;
         swapped_ff   <= swapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      mark_ff     <= mark_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES_C)
      else $error("element count beyond capacity");

   a_fwd_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbs_pkg::S_F_CMP) |-> (j_ff >= lo_ff) && (j_ff < hi_ff))
      else $error("forward step outside unsorted range");

   a_bwd_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbs_pkg::S_B_CMP) |-> (j_ff > lo_ff) && (j_ff <= hi_ff))
      else $error("backward step outside unsorted range");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbs_pkg::S_E_WR) |-> (CNT_W'(k_ff) < count_ff))
      else $error("emit index past element count");

   a_set_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bbs_pkg::S_E_WR) && emit_last && (!rsp_valid_ff || rsp_ch.ready)
      |=> rsp_valid_ff && rsp_data_ff.end_of_set && (count_ff == '0))
      else $error("final beat not marked or set not cleared");

endmodule

/* verif/tb_bidirectional_bubble_sorter_unit.sv */
// Testbench for the bubble sorter: random valid/ready traffic against a shaker-sort predictor.
module tb_bidirectional_bubble_sorter_unit;

   localparam int ENTRIES = 32;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_BEATS = 180;
   localparam int SETTLE_CYCLES = 64;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

   logic clock;
   logic reset;

   bbs_stream_if #(.payload_type(bbs_pkg::req_payload_type)) req_ch ();
   bbs_stream_if #(.payload_type(bbs_pkg::rsp_payload_type)) rsp_ch ();

   bidirectional_bubble_sorter_unit #(.ENTRIES(ENTRIES)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   bbs_pkg::req_payload_type pending_beats[$];
   bbs_pkg::rsp_payload_type sorted_expect[$];
   logic signed [31:0]       set_words[ENTRIES];
   int                       set_count = 0;
   logic                     set_dropped = 1'b0;

   int total_beats = 1;
   int beats_taken = 0;
   int results_seen = 0;
   int sets_closed = 0;
   int overflow_sets = 0;
   int error_count = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               sorted_expect.size());
      $display("tb_bidirectional_bubble_sorter_unit: FAIL");
      $finish;
   end

   // Idle percentage: first third sender 25 / receiver 45, then swapped, then none.
   function automatic int idle_pct(input bit sender_side);
      int phase;
      phase = (beats_taken * 3) / total_beats;
      if (phase == 0) return sender_side ? 25 : 45;
      if (phase == 1) return sender_side ? 45 : 25;
      return 0;
   endfunction

   // Cocktail shaker sort over the held words; each pass shrinks to its last swap.
   function automatic void shaker_order();
      int                 lo;
      int                 hi;
      int                 mark;
      int                 j;
      bit                 swapped;
      logic signed [31:0] t;
      if (set_count < 2) return;
      lo = 0;
      hi = set_count - 1;
      while (lo < hi) begin
         swapped = 1'b0;
         mark = lo;
         for (j = lo; j < hi; j++) begin
            if (set_words[j] > set_words[j + 1]) begin
               t = set_words[j];
               set_words[j] = set_words[j + 1];
               set_words[j + 1] = t;
               mark = j;
               swapped = 1'b1;
            end
         end
         if (!swapped) break;
         hi = mark;
         swapped = 1'b0;
         mark = hi;
         for (j = hi; j > lo; j--) begin
            if (set_words[j - 1] > set_words[j]) begin
               t = set_words[j - 1];
               set_words[j - 1] = set_words[j];
               set_words[j] = t;
               mark = j;
               swapped = 1'b1;
            end
         end
         if (!swapped) break;
         lo = mark;
      end
   endfunction

   // Take one accepted beat into the predicted store; a closing beat yields the sorted set.
   function automatic void absorb_element(input bbs_pkg::req_payload_type beat);
      bbs_pkg::rsp_payload_type r;
      if (set_count < ENTRIES) begin
         set_words[set_count] = beat.value;
         set_count++;
      end else begin
         set_dropped = 1'b1;
      end
      if (!beat.is_last) return;
      shaker_order();
      for (int k = 0; k < set_count; k++) begin
         r.sorted_value = set_words[k];
         r.end_of_set = (k == set_count - 1);
         r.overflow = set_dropped;
         sorted_expect.push_back(r);
      end
      sets_closed++;
      if (set_dropped) overflow_sets++;
      set_count = 0;
      set_dropped = 1'b0;
   endfunction

   function automatic void push_elem(input logic signed [31:0] v, input logic last);
      bbs_pkg::req_payload_type b;
      b.value = v;
      b.is_last = last;
      pending_beats.push_back(b);
   endfunction

   function automatic void queue_random_set(input int n);
      int                 mode;
      logic signed [31:0] v;
      mode = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
         // mode 3 mixes the other styles element by element
         case ((mode == 3) ? $urandom_range(2) : mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(6)) - 3;
            default: begin
               case ($urandom_range(3))
                  0: v = WORD_MIN;
                  1: v = WORD_MAX;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
         endcase
         push_elem(v, i == n - 1);
      end
   endfunction

   task automatic note_mismatch(input string field, input logic signed [31:0] e,
                                input logic signed [31:0] a);
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, e, a);
   endtask

   // Driver: hold a beat until taken, otherwise present the next one or idle.
   always @(posedge clock) begin : drive_req
      bbs_pkg::req_payload_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_element(req_ch.payload);
            beats_taken++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
               nxt = pending_beats.pop_front();
               req_ch.payload <= nxt;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest expected one.
   always @(posedge clock) begin : watch_rsp
      bbs_pkg::rsp_payload_type exp_beat;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (sorted_expect.size() == 0) begin
               note_mismatch("unexpected beat, sorted_value", 'x, rsp_ch.payload.sorted_value);
            end else begin
               exp_beat = sorted_expect.pop_front();
               if (rsp_ch.payload.sorted_value !== exp_beat.sorted_value)
                  note_mismatch("sorted_value", exp_beat.sorted_value,
                                rsp_ch.payload.sorted_value);
               if (rsp_ch.payload.end_of_set !== exp_beat.end_of_set)
                  note_mismatch("end_of_set", exp_beat.end_of_set, rsp_ch.payload.end_of_set);
               if (rsp_ch.payload.overflow !== exp_beat.overflow)
                  note_mismatch("overflow", exp_beat.overflow, rsp_ch.payload.overflow);
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;

      // single element, extremes in reverse, all equal, mixed signs, sorted, reverse sorted
      push_elem(WORD_MAX, 1'b1);
      push_elem(WORD_MAX, 1'b0);
      push_elem(WORD_MIN, 1'b1);
      push_elem(5, 1'b0);
      push_elem(5, 1'b0);
      push_elem(5, 1'b1);
      push_elem(0, 1'b0);
      push_elem(-1, 1'b0);
      push_elem(1, 1'b0);
      push_elem(-1, 1'b1);
      push_elem(1, 1'b0);
      push_elem(2, 1'b0);
      push_elem(3, 1'b0);
      push_elem(4, 1'b1);
      for (int i = 4; i >= -1; i--) push_elem(i, i == -1);

      // full store with drops (closing beat dropped too), then exactly full
      queue_random_set(ENTRIES + 2);
      queue_random_set(ENTRIES);
      while (pending_beats.size() < RANDOM_BEATS) begin
         n = ($urandom_range(99) < 12) ? $urandom_range(ENTRIES + 4, ENTRIES - 4)
                                       : $urandom_range(10, 1);
         if (n > RANDOM_BEATS - pending_beats.size())
            n = RANDOM_BEATS - pending_beats.size();
         queue_random_set(n);
      end
      total_beats = pending_beats.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_ch.valid || sorted_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d elements in %0d sets (%0d with dropped elements), checked %0d results.",
               beats_taken, sets_closed, overflow_sets, results_seen);
      $display("Mismatches: %0d, cycles: %0d", error_count, cycle_count);
      if (error_count == 0 && sorted_expect.size() == 0)
         $display("tb_bidirectional_bubble_sorter_unit: PASS");
      else
         $display("tb_bidirectional_bubble_sorter_unit: FAIL");
      $finish;
   end

endmodule
